// File: sv/cilr_pkg.sv
// ----------------------------------------------------------------------------
// cilr_pkg
// Shared types and constants for the color interpolated line rasterizer.
// ----------------------------------------------------------------------------
package cilr_pkg;

	localparam int unsigned CILR_IMAGE_SIZE = 512;

	localparam int unsigned COORD_W   = 9;
	localparam int unsigned COLOR_W   = 8;
	localparam int unsigned DELTA_W   = COORD_W + 1;
	localparam int unsigned DEC_W     = DELTA_W + 2;
	localparam int unsigned NUM_CH    = 3;
	localparam int unsigned DIV_STEPS = COLOR_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// item codes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] first_red;
		logic [COLOR_W-1:0] first_green;
		logic [COLOR_W-1:0] first_blue;
		logic [COLOR_W-1:0] second_red;
		logic [COLOR_W-1:0] second_green;
		logic [COLOR_W-1:0] second_blue;
	} cilr_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last_pixel;
	} cilr_out_t;

	// controller -> datapath
	typedef struct packed {
		logic start_load;
		logic step_load;
		logic div_step;
		logic out_load;
	} cilr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic line_active;
	} cilr_stat_t;

endpackage

// File: sv/cilr_if.sv
// ----------------------------------------------------------------------------
// cilr_if
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface cilr_in_if import cilr_pkg::*; ();
	logic     valid;
	logic     ready;
	cilr_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cilr_out_if import cilr_pkg::*; ();
	logic      valid;
	logic      ready;
	cilr_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/cilr_ctrl.sv
// ----------------------------------------------------------------------------
// cilr_ctrl
// Sequencer: takes beats, runs the color-step divide, hands results out.
// ----------------------------------------------------------------------------
module cilr_ctrl import cilr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_mode,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  cilr_stat_t stat,
	output cilr_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [1:0]           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_START) begin
						cmd.start_load = 1'b1;
						state_d        = S_DIV;
					end else if (stat.line_active) begin
						cmd.step_load = 1'b1;
						state_d       = S_EMIT;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.out_load = !out_valid_q || out_ready;
				if (cmd.out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start_load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/cilr_dp.sv
// ----------------------------------------------------------------------------
// cilr_dp
// Line state, midpoint stepper, per-channel color stepper with a bit-serial
// divider, and the output register.
// ----------------------------------------------------------------------------
module cilr_dp import cilr_pkg::*; #(
	parameter int unsigned IMAGE_SIZE = CILR_IMAGE_SIZE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cilr_in_t   in_data,
	input  cilr_cmd_t  cmd,
	output cilr_stat_t stat,
	output cilr_out_t  out_data
);

	localparam int unsigned CMP_W = $clog2(IMAGE_SIZE) + 1;
	localparam logic [CMP_W-1:0] IMG_LIM = CMP_W'(IMAGE_SIZE);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(IMAGE_SIZE - 1);

	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
		logic [CMP_W+COORD_W-1:0] wide;
		wide = (CMP_W+COORD_W)'(v);
		if (wide >= (CMP_W+COORD_W)'(IMG_LIM))
			return COORD_MAX;
		return v;
	endfunction

	// line state
	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [DEC_W-1:0]   dec_q;
	logic [DELTA_W-1:0] maj_q, mnr_q, steps_q;
	logic               y_major_q, y_down_q, active_q, last_q;

	// channel state
	logic [COLOR_W-1:0] val_q  [NUM_CH];
	logic [COLOR_W-1:0] quo_q  [NUM_CH];
	logic [DELTA_W-1:0] rem_q  [NUM_CH];
	logic [DELTA_W-1:0] err_q  [NUM_CH];
	logic               fall_q [NUM_CH];
	logic [COLOR_W-1:0] dvd_q  [NUM_CH];

	cilr_out_t out_q;

	// start decode
	logic [COORD_W-1:0] x0c, y0c, x1c, y1c, sx, sy, ex, ey;
	logic               swap, y_down, y_major;
	logic [DELTA_W-1:0] dx, ady, maj, mnr;
	logic [DEC_W-1:0]   dec_init;
	logic [COLOR_W-1:0] ca [NUM_CH];
	logic [COLOR_W-1:0] cb [NUM_CH];
	logic [COLOR_W-1:0] c0 [NUM_CH];
	logic [COLOR_W-1:0] c1 [NUM_CH];
	logic [COLOR_W-1:0] mag [NUM_CH];

	always_comb begin
		x0c = clamp(in_data.start_x);
		y0c = clamp(in_data.start_y);
		x1c = clamp(in_data.end_x);
		y1c = clamp(in_data.end_y);
		swap = (x1c < x0c) || ((x1c == x0c) && (y1c < y0c));
		sx = swap ? x1c : x0c;
		sy = swap ? y1c : y0c;
		ex = swap ? x0c : x1c;
		ey = swap ? y0c : y1c;
		dx = {1'b0, ex} - {1'b0, sx};
		y_down = ey < sy;
		ady = y_down ? ({1'b0, sy} - {1'b0, ey}) : ({1'b0, ey} - {1'b0, sy});
		y_major = ady > dx;
		maj = y_major ? ady : dx;
		mnr = y_major ? dx : ady;
		dec_init = {1'b0, mnr, 1'b0} - {2'b00, maj};
		ca[0] = in_data.first_red;
		ca[1] = in_data.first_green;
		ca[2] = in_data.first_blue;
		cb[0] = in_data.second_red;
		cb[1] = in_data.second_green;
		cb[2] = in_data.second_blue;
		for (int c = 0; c < NUM_CH; c++) begin
			c0[c]  = swap ? cb[c] : ca[c];
			c1[c]  = swap ? ca[c] : cb[c];
			mag[c] = (c1[c] >= c0[c]) ? (c1[c] - c0[c]) : (c0[c] - c1[c]);
		end
	end

	// midpoint step
	logic               minor_step;
	logic [DEC_W-1:0]   dec_nxt;
	logic [DELTA_W-1:0] steps_nxt;

	always_comb begin
		minor_step = !dec_q[DEC_W-1] && (dec_q != '0);
		dec_nxt = dec_q + {1'b0, mnr_q, 1'b0}
			- (minor_step ? {1'b0, maj_q, 1'b0} : {DEC_W{1'b0}});
		steps_nxt = steps_q - 1'b1;
	end

	// color step and divide step
	logic [DELTA_W:0]   err_sum [NUM_CH];
	logic               carry   [NUM_CH];
	logic [DELTA_W-1:0] err_nxt [NUM_CH];
	logic [COLOR_W:0]   inc     [NUM_CH];
	logic [COLOR_W-1:0] val_nxt [NUM_CH];
	logic [DELTA_W-1:0] r_sh    [NUM_CH];
	logic               ge      [NUM_CH];
	logic [DELTA_W-1:0] rem_div [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			err_sum[c] = {1'b0, err_q[c]} + {1'b0, rem_q[c]};
			carry[c]   = err_sum[c] >= {1'b0, maj_q};
			err_nxt[c] = carry[c] ? DELTA_W'(err_sum[c] - {1'b0, maj_q})
				: err_sum[c][DELTA_W-1:0];
			inc[c]     = {1'b0, quo_q[c]} + {{COLOR_W{1'b0}}, carry[c]};
			val_nxt[c] = fall_q[c] ? (val_q[c] - inc[c][COLOR_W-1:0])
				: (val_q[c] + inc[c][COLOR_W-1:0]);
			// restoring divide, one quotient bit per cycle
			r_sh[c]    = {rem_q[c][DELTA_W-2:0], dvd_q[c][COLOR_W-1]};
			ge[c]      = r_sh[c] >= maj_q;
			rem_div[c] = ge[c] ? (r_sh[c] - maj_q) : r_sh[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd.start_load) begin
			active_q <= maj != '0;
		end else if (cmd.step_load) begin
			active_q <= steps_nxt != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			cur_x_q   <= sx;
			cur_y_q   <= sy;
			dec_q     <= dec_init;
			maj_q     <= maj;
			mnr_q     <= mnr;
			steps_q   <= maj;
			y_major_q <= y_major;
			y_down_q  <= y_down;
			last_q    <= maj == '0;
			for (int c = 0; c < NUM_CH; c++) begin
				val_q[c]  <= c0[c];
				fall_q[c] <= c1[c] < c0[c];
				err_q[c]  <= '0;
				rem_q[c]  <= '0;
				quo_q[c]  <= '0;
				dvd_q[c]  <= mag[c];
			end
		end else if (cmd.step_load) begin
			dec_q   <= dec_nxt;
			steps_q <= steps_nxt;
			last_q  <= steps_nxt == '0;
			if (y_major_q || minor_step)
				cur_y_q <= y_down_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
			if (!y_major_q || minor_step)
				cur_x_q <= cur_x_q + 1'b1;
			for (int c = 0; c < NUM_CH; c++) begin
				err_q[c] <= err_nxt[c];
				val_q[c] <= val_nxt[c];
			end
		end else if (cmd.div_step) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c] <= rem_div[c];
				quo_q[c] <= {quo_q[c][COLOR_W-2:0], ge[c]};
				dvd_q[c] <= {dvd_q[c][COLOR_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_q.pixel_x    <= cur_x_q;
			out_q.pixel_y    <= cur_y_q;
			out_q.red        <= val_q[0];
			out_q.green      <= val_q[1];
			out_q.blue       <= val_q[2];
			out_q.last_pixel <= last_q;
		end
	end

	assign stat.line_active = active_q;
	assign out_data         = out_q;

endmodule

// File: sv/color_interpolated_line_rasterizer.sv
// ----------------------------------------------------------------------------
// color_interpolated_line_rasterizer
// Midpoint line rasterizer in all octants with linear RGB interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   line_in   : command beats. mode start loads both endpoints and colors and
//               produces the first pixel; mode step produces the next pixel.
//               A step with no line in progress is consumed with no result.
//   pixel_out : one beat per pixel: coordinates, color, and last_pixel on the
//               line's final endpoint (also on a single-point line).
// Timing:
//   step  : the line steps on acceptance, then the emit phase loads the
//           pixel into the output register.
//   start : load, bit-serial color-step divide (one quotient bit per cycle,
//           all three channels side by side), then the output register.
//   line_in is held off through the divide and the emit cycle. The emit
//   cycle stretches while an earlier pixel still waits in the output
//   register, so a command is taken while that pixel waits, but a new
//   result is never written over it.
// Reset: arst_n clears the sequencer, the output valid and the active line.
// Stall: pixel_out holds its beat until ready; no result is dropped.
// ----------------------------------------------------------------------------
module color_interpolated_line_rasterizer import cilr_pkg::*; #(
	parameter int unsigned IMAGE_SIZE = CILR_IMAGE_SIZE
) (
	input logic          clk,
	input logic          arst_n,
	cilr_in_if.sink      line_in,
	cilr_out_if.source   pixel_out
);

	cilr_cmd_t  cmd;
	cilr_stat_t stat;

	// sequencer: owns handshakes and the divide count
	cilr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (line_in.valid),
		.in_mode   (line_in.data.mode),
		.in_ready  (line_in.ready),
		.out_valid (pixel_out.valid),
		.out_ready (pixel_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: line and color state plus output register
	cilr_dp #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (line_in.data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (pixel_out.data)
	);

endmodule

// File: sv/cilr_checker.sv
// ----------------------------------------------------------------------------
// cilr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module cilr_checker import cilr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      in_mode,
	input logic      out_valid,
	input logic      out_ready,
	input cilr_out_t out_data
);

	// stalled pixel beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pixel beat changed under stall");

	// a start beat occupies the divider next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == MODE_START) |=> !in_ready)
		else $error("command taken during color-step divide");

	// a new pixel only comes from the emit phase, where commands are held off
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("pixel appeared without an emit phase");

endmodule

bind color_interpolated_line_rasterizer cilr_checker u_cilr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (line_in.valid),
	.in_ready  (line_in.ready),
	.in_mode   (line_in.data.mode),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_data  (pixel_out.data)
);
